### hdl/drlm_pkg.sv
`timescale 1ns / 1ps
package drlm_pkg;

  localparam int MAX_RECTS_DEF = 64;
  localparam int COORD_W       = 16;
  localparam int SIZE_W        = 15;
  localparam int COUNT_W       = 7;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] b;
  } rect_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_right;
    logic signed [COORD_W-1:0] rect_bottom;
  } in_item_t;

  typedef struct packed {
    logic               is_dirty_hit;
    logic               whole_dirty;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic contains;
    logic overlap;
  } cmp_res_t;

endpackage

### hdl/drlm_chan_if.sv
`timescale 1ns / 1ps
interface drlm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/drlm_ram.sv
`timescale 1ns / 1ps
module drlm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

### hdl/drlm_cmp.sv
`timescale 1ns / 1ps
module drlm_cmp (
  input  drlm_pkg::rect_t    a,
  input  drlm_pkg::rect_t    e,
  output drlm_pkg::cmp_res_t res,
  output drlm_pkg::rect_t    bbox
);
  import drlm_pkg::*;

  always_comb begin
    res.contains = (a.l >= e.l) && (a.t >= e.t) && (a.r <= e.r) && (a.b <= e.b);
    res.overlap  = (a.l < e.r) && (e.l < a.r) && (a.t < e.b) && (e.t < a.b);
    bbox.l = (e.l < a.l) ? e.l : a.l;
    bbox.t = (e.t < a.t) ? e.t : a.t;
    bbox.r = (e.r > a.r) ? e.r : a.r;
    bbox.b = (e.b > a.b) ? e.b : a.b;
  end
endmodule

### hdl/dirty_rect_list_merge.sv
`timescale 1ns / 1ps
// Dirty rectangle list with merging, on a screen of configured size.
// Input channel in_ch carries one command per transaction: add or query a
// half-open rectangle, clear, or do nothing. Output channel out_ch returns
// exactly one result per input transaction: query hit, whole-screen flag
// and the number of rectangles held afterwards. cfg_we/cfg_index/cfg_data
// write the screen width (index 0) or height (index 1); either write marks
// the whole screen dirty. Write configuration only while the block is idle.
// The block handles one transaction at a time; in_ch.ready is high only in
// idle. A single compare unit is stepped over the list held in a RAM with a
// registered read, so every entry visited is first read and then compared.
// The result register and in_ch.ready are set together when the block
// returns to idle. Each merge moves every later entry up one place, a read
// and then a write for each, and then rescans the list from the first entry.
// When out_ch stalls, the result holds in its register; the block takes the
// next transaction and waits at its end until the register is free.
// Reset empties the list, clears the whole-screen flag and the screen size.
module dirty_rect_list_merge #(
  parameter int MAX_RECTS = drlm_pkg::MAX_RECTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  drlm_chan_if.sink                   in_ch,
  drlm_chan_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [drlm_pkg::SIZE_W-1:0] cfg_data
);
  import drlm_pkg::*;

  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_SH    = 7'b0010000,
    S_SH_WR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  rect_t           x_r, x_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   sh_r, sh_nxt;
  logic            whole_r, whole_nxt;
  logic            hit_r, hit_nxt;
  logic [SIZE_W-1:0] sw_r, sw_nxt;
  logic [SIZE_W-1:0] sh_size_r, sh_size_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  rect_t           ram_wdata;
  logic [IW-1:0]   ram_raddr;
  rect_t           ram_rdata;
  cmp_res_t        cmp_res;
  rect_t           cmp_bbox;

  logic signed [COORD_W-1:0] sw_ext;
  logic signed [COORD_W-1:0] sh_ext;
  logic                      rejected;

  drlm_ram #(
    .WIDTH ($bits(rect_t)),
    .DEPTH (MAX_RECTS),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  drlm_cmp u_cmp (
    .a    (x_r),
    .e    (ram_rdata),
    .res  (cmp_res),
    .bbox (cmp_bbox)
  );

  assign sw_ext   = $signed({1'b0, sw_r});
  assign sh_ext   = $signed({1'b0, sh_size_r});
  assign rejected = (x_r.l >= sw_ext) || (x_r.t >= sh_ext) ||
                    (x_r.l >= x_r.r) || (x_r.t >= x_r.b);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    x_nxt         = x_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    sh_nxt        = sh_r;
    whole_nxt     = whole_r;
    hit_nxt       = hit_r;
    sw_nxt        = sw_r;
    sh_size_nxt   = sh_size_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[IW-1:0];
    ram_wdata     = x_r;
    ram_raddr     = idx_r[IW-1:0];

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.data.cmd;
          x_nxt.l   = in_ch.data.rect_left;
          x_nxt.t   = in_ch.data.rect_top;
          x_nxt.r   = in_ch.data.rect_right;
          x_nxt.b   = in_ch.data.rect_bottom;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        hit_nxt   = 1'b0;
        idx_nxt   = '0;
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_CLEAR: begin
            cnt_nxt   = '0;
            whole_nxt = 1'b0;
          end
          CMD_QUERY: begin
            if (!rejected) begin
              if (whole_r) begin
                hit_nxt = 1'b1;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          end
          CMD_ADD: begin
            if (!whole_r && !rejected) begin
              if (cnt_r >= CW'(MAX_RECTS)) begin
                whole_nxt = 1'b1;
              end else begin
                if (x_r.r > sw_ext) x_nxt.r = sw_ext;
                if (x_r.b > sh_ext) x_nxt.b = sh_ext;
                state_nxt = S_SCAN;
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (idx_r < cnt_r) begin
          ram_raddr = idx_r[IW-1:0];
          state_nxt = S_CMP;
        end else begin
          if (cmd_r == CMD_ADD) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_r[IW-1:0];
            ram_wdata = x_r;
            cnt_nxt   = cnt_r + CW'(1);
          end
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        if (cmd_r == CMD_QUERY) begin
          if (cmp_res.overlap) begin
            hit_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_SCAN;
          end
        end else if (cmp_res.contains) begin
          state_nxt = S_DONE;
        end else if (cmp_res.overlap) begin
          x_nxt     = cmp_bbox;
          cnt_nxt   = cnt_r - CW'(1);
          sh_nxt    = idx_r;
          state_nxt = S_SH;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SH: begin
        if (sh_r < cnt_r) begin
          ram_raddr = IW'(sh_r + CW'(1));
          state_nxt = S_SH_WR;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_r[IW-1:0];
        ram_wdata = ram_rdata;
        sh_nxt    = sh_r + CW'(1);
        state_nxt = S_SH;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.is_dirty_hit = hit_r;
          out_nxt.whole_dirty  = whole_r;
          out_nxt.entry_count  = COUNT_W'(cnt_r);
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      whole_nxt = 1'b1;
      case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  sw_nxt = cfg_data;
        REG_SCREEN_HEIGHT: sh_size_nxt = cfg_data;
        default:           sw_nxt = sw_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      whole_r     <= 1'b0;
      sw_r        <= '0;
      sh_size_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      whole_r     <= whole_nxt;
      sw_r        <= sw_nxt;
      sh_size_r   <= sh_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    x_r   <= x_nxt;
    idx_r <= idx_nxt;
    sh_r  <= sh_nxt;
    hit_r <= hit_nxt;
    out_r <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RECTS))
    else $error("rectangle count beyond capacity");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_CHECK)
    else $error("accepted transaction not decoded");

  a_cmp_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> idx_r < cnt_r)
    else $error("compare on entry outside the list");

  a_whole_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(whole_r) |-> !$past(rst_n) ||
      ($past(state_r) == S_CHECK && $past(cmd_r) == CMD_CLEAR))
    else $error("whole-screen flag dropped without clear");
`endif
endmodule

### sim/tb_dirty_rect_list_merge.sv
`timescale 1ns / 1ps
module tb_dirty_rect_list_merge;
  import drlm_pkg::*;

  localparam int LIST_DEPTH   = MAX_RECTS_DEF;
  localparam int LONG_HOLD    = 400;
  localparam int TARGET_ITEMS = 1450;

  typedef struct {
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] b;
  } dirty_box_t;

  class dirty_list_scoreboard;
    dirty_box_t                held[LIST_DEPTH];
    int                        held_n;
    bit                        whole;
    logic signed [COORD_W-1:0] scr_w;
    logic signed [COORD_W-1:0] scr_h;
    out_item_t                 expected_q[$];
    int                        mismatches;
    int                        n_cmds;
    int                        n_results;
    int                        n_hits;
    int                        n_merges;
    int                        n_full;
    int                        peak_n;

    function new();
      held_n     = 0;
      whole      = 1'b0;
      scr_w      = '0;
      scr_h      = '0;
      mismatches = 0;
      n_cmds     = 0;
      n_results  = 0;
      n_hits     = 0;
      n_merges   = 0;
      n_full     = 0;
      peak_n     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [SIZE_W-1:0] val);
      if (idx == REG_SCREEN_WIDTH) begin
        scr_w = $signed({1'b0, val});
      end else begin
        scr_h = $signed({1'b0, val});
      end
      whole = 1'b1;
    endfunction

    function bit dropped(dirty_box_t x);
      return x.l >= scr_w || x.t >= scr_h || x.l >= x.r || x.t >= x.b;
    endfunction

    function bit overlap(dirty_box_t a, dirty_box_t c);
      return a.l < c.r && c.l < a.r && a.t < c.b && c.t < a.b;
    endfunction

    function void add_box(dirty_box_t x);
      bit again;
      if (whole || dropped(x)) return;
      if (held_n == LIST_DEPTH) begin
        whole = 1'b1;
        n_full++;
        return;
      end
      if (x.r > scr_w) x.r = scr_w;
      if (x.b > scr_h) x.b = scr_h;
      do begin
        again = 1'b0;
        for (int i = 0; i < held_n; i++) begin
          if (x.l >= held[i].l && x.t >= held[i].t &&
              x.r <= held[i].r && x.b <= held[i].b) return;
          if (overlap(x, held[i])) begin
            if (held[i].l < x.l) x.l = held[i].l;
            if (held[i].t < x.t) x.t = held[i].t;
            if (held[i].r > x.r) x.r = held[i].r;
            if (held[i].b > x.b) x.b = held[i].b;
            for (int j = i; j < held_n - 1; j++) held[j] = held[j + 1];
            held_n--;
            n_merges++;
            again = 1'b1;
            break;
          end
        end
      end while (again);
      held[held_n] = x;
      held_n++;
      if (held_n > peak_n) peak_n = held_n;
    endfunction

    function bit probe(dirty_box_t x);
      if (dropped(x)) return 1'b0;
      if (whole) return 1'b1;
      for (int i = 0; i < held_n; i++) begin
        if (overlap(x, held[i])) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_input(in_item_t it);
      dirty_box_t x;
      out_item_t  exp_res;
      x.l = it.rect_left;
      x.t = it.rect_top;
      x.r = it.rect_right;
      x.b = it.rect_bottom;
      exp_res.is_dirty_hit = 1'b0;
      case (it.cmd)
        CMD_ADD:   add_box(x);
        CMD_QUERY: exp_res.is_dirty_hit = probe(x);
        CMD_CLEAR: begin
          held_n = 0;
          whole  = 1'b0;
        end
        default: ;
      endcase
      exp_res.whole_dirty = whole;
      exp_res.entry_count = COUNT_W'(held_n);
      n_hits += exp_res.is_dirty_hit;
      n_cmds++;
      expected_q.insert(expected_q.size(), exp_res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with nothing outstanding: hit %0b whole %0b count %0d",
                   n_results, got.is_dirty_hit, got.whole_dirty, got.entry_count);
        return;
      end
      want = expected_q.pop_front();
      if (got.is_dirty_hit !== want.is_dirty_hit || got.whole_dirty !== want.whole_dirty ||
          got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d mismatch: expected hit %0b whole %0b count %0d, ",
                    "got hit %0b whole %0b count %0d"},
                   n_results, want.is_dirty_hit, want.whole_dirty, want.entry_count,
                   got.is_dirty_hit, got.whole_dirty, got.entry_count);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_index;
  logic [SIZE_W-1:0]   cfg_data;
  int                  burst_left = 0;
  int                  n_sent = 0;
  int                  long_hold_reqs = 0;

  drlm_chan_if #(.T(in_item_t))  in_if ();
  drlm_chan_if #(.T(out_item_t)) out_if ();

  dirty_list_scoreboard sb = new();

  dirty_rect_list_merge u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
  end

  initial begin
    #2000000000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stall patterns, plus a long hold on request
  initial begin
    int mode;
    int span;
    int hold_left;
    int phase;
    int served;
    mode         = 0;
    span         = 0;
    hold_left    = 0;
    phase        = 0;
    served       = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (long_hold_reqs != served) begin
        served        = long_hold_reqs;
        hold_left     = LONG_HOLD - 1;
        out_if.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 150);
        end
        span--;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 2) != 0);
          2:       out_if.ready <= (phase % 4 == 0);
          default: out_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  function automatic in_item_t mk(cmd_t c, int l, int t, int r, int b);
    in_item_t it;
    it.cmd         = c;
    it.rect_left   = sat16(l);
    it.rect_top    = sat16(t);
    it.rect_right  = sat16(r);
    it.rect_bottom = sat16(b);
    return it;
  endfunction

  function automatic in_item_t rand_box(cmd_t c, int w, int h, int div);
    int l;
    int t;
    l = int'($urandom_range(0, w + 7)) - 4;
    t = int'($urandom_range(0, h + 7)) - 4;
    return mk(c, l, t, l + int'($urandom_range(1, w / div + 1)),
              t + int'($urandom_range(1, h / div + 1)));
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd         = cmd_t'($urandom_range(0, 3));
    it.rect_left   = 16'($urandom);
    it.rect_top    = 16'($urandom);
    it.rect_right  = 16'($urandom);
    it.rect_bottom = 16'($urandom);
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12))
        @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 30);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    burst_left--;
    n_sent++;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0 || !in_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[SIZE_W-1:0];
    sb.set_reg(idx, val[SIZE_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_screen(int w, int h);
    drain();
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
  endtask

  initial begin
    int       w;
    int       h;
    int       div;
    int       episode;
    int       sx;
    int       sy;
    int       r;
    int       l;
    int       t;
    in_item_t it;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_we       = 1'b0;
    cfg_index    = 1'b0;
    cfg_data     = '0;
    rst_n        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero-size screen: a box wholly above-left is still kept
    send_item(mk(CMD_ADD, -20, -20, -5, -5));
    send_item(mk(CMD_QUERY, -10, -10, -8, -8));
    send_item(mk(CMD_QUERY, 0, 0, 5, 5));
    send_item(mk(CMD_NOP, -1, -1, -1, -1));
    send_item(mk(CMD_CLEAR, 0, 0, 0, 0));

    set_screen(640, 480);
    send_item(mk(CMD_ADD, 10, 10, 50, 50));
    send_item(mk(CMD_QUERY, 600, 400, 700, 500));
    send_item(mk(CMD_CLEAR, 0, 0, 0, 0));
    send_item(mk(CMD_ADD, 10, 10, 50, 50));
    send_item(mk(CMD_ADD, 20, 20, 30, 30));
    send_item(mk(CMD_ADD, 50, 10, 90, 50));
    send_item(mk(CMD_QUERY, 0, 0, 10, 10));
    send_item(mk(CMD_QUERY, 40, 40, 45, 45));
    send_item(mk(CMD_ADD, 30, 30, 30, 40));
    send_item(mk(CMD_ADD, 100, 100, 90, 200));
    send_item(mk(CMD_ADD, 640, 0, 700, 10));
    send_item(mk(CMD_ADD, 0, 480, 10, 500));
    send_item(mk(CMD_ADD, 600, 400, 32767, 32767));
    send_item(mk(CMD_ADD, 45, 5, 55, 20));
    send_item(mk(CMD_QUERY, 639, 479, 640, 480));
    send_item(mk(CMD_ADD, -32768, -32768, 32767, 32767));
    send_item(mk(CMD_QUERY, 32767, 32767, -32768, -32768));
    send_item(mk(CMD_NOP, 0, 0, 0, 0));
    send_item(mk(CMD_CLEAR, 0, 0, 0, 0));

    w       = 640;
    h       = 480;
    episode = 0;
    while (n_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // fill the list with disjoint boxes on a grid, then overflow it
        w  = $urandom_range(100, 32767);
        h  = $urandom_range(100, 32767);
        set_screen(w, h);
        send_item(mk(CMD_CLEAR, 0, 0, 0, 0));
        sx = w / 10;
        sy = h / 8;
        for (int k = 0; k < 70; k++) begin
          l = (k % 10) * sx;
          t = (k / 10) * sy;
          send_item(mk(CMD_ADD, l, t, l + int'($urandom_range(1, sx - 1)),
                       t + int'($urandom_range(1, sy - 1))));
          if (k % 9 == 4) send_item(rand_box(CMD_QUERY, w, h, 8));
        end
        send_item(rand_box(CMD_QUERY, w, h, 4));
        send_item(mk(CMD_CLEAR, 0, 0, 0, 0));
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          r = $urandom_range(0, 9);
          if (r == 9) begin
            h = $urandom_range(8, 400);
            drain();
            write_reg(REG_SCREEN_HEIGHT, h);
          end else begin
            case (r)
              0: begin
                w = 0;
                h = $urandom_range(0, 32767);
              end
              1: begin
                w = $urandom_range(0, 32767);
                h = 0;
              end
              2: begin
                w = 32767;
                h = 32767;
              end
              3: begin
                w = 1;
                h = 1;
              end
              4, 5: begin
                w = $urandom_range(1, 32767);
                h = $urandom_range(1, 32767);
              end
              default: begin
                w = $urandom_range(8, 300);
                h = $urandom_range(8, 300);
              end
            endcase
            set_screen(w, h);
          end
          if ($urandom_range(0, 7) != 0) send_item(mk(CMD_CLEAR, 0, 0, 0, 0));
        end
        if (episode % 17 == 5) long_hold_reqs++;
        div = $urandom_range(2, 24);
        repeat ($urandom_range(15, 60)) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            send_item(rand_box(CMD_ADD, w, h, div));
          end else if (r < 70) begin
            send_item(rand_box(CMD_QUERY, w, h, div));
          end else if (r < 76) begin
            send_item(rand_box(CMD_ADD, w, h, 1));
          end else if (r < 86) begin
            send_item(noise_item());
          end else begin
            it = noise_item();
            it.cmd = (r < 90) ? CMD_CLEAR : (r < 93) ? CMD_NOP : CMD_QUERY;
            send_item(it);
          end
        end
      end
      episode++;
    end

    drain();
    repeat (300) @(posedge clk);
    $display("run summary: %0d commands, %0d results, %0d query hits, %0d merges",
             sb.n_cmds, sb.n_results, sb.n_hits, sb.n_merges);
    $display("run summary: %0d full-list overflows, peak occupancy %0d, %0d episodes",
             sb.n_full, sb.peak_n, episode);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
